// ----- hw/rtl/acfe_pkg.sv -----
// acfe_pkg: shared types, codes and constants for the IR frame encoder.
// No dependencies; used by every module under hw/rtl.
package acfe_pkg;

  localparam int unsigned FRAME_BITS = 48;
  localparam int unsigned PULSES     = FRAME_BITS + 2;
  localparam int unsigned IDX_W      = $clog2(PULSES);

  localparam int unsigned MARK_W  = 14;
  localparam int unsigned SPACE_W = 13;

  // requested / current mode codes
  localparam logic [2:0] MODE_OFF   = 3'd0;
  localparam logic [2:0] MODE_COOL  = 3'd1;
  localparam logic [2:0] MODE_AUTO  = 3'd2;
  localparam logic [2:0] MODE_DRY   = 3'd3;
  localparam logic [2:0] MODE_CLEAN = 3'd4;

  // input kinds
  localparam logic ACT_COMMAND = 1'b0;
  localparam logic ACT_REPORT  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_TEMP_MIN  = 2'd0;
  localparam logic [1:0] REG_TEMP_MAX  = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic [FRAME_BITS-1:0] FRAME_RESET = 48'hC001E0004000;

  // frame field positions
  localparam int unsigned POS_COUNT = 44;
  localparam int unsigned POS_MODE  = 36;
  localparam int unsigned POS_SPEED = 24;
  localparam int unsigned POS_LEVEL = 16;
  localparam int unsigned POS_POWER = 15;
  localparam int unsigned POS_PMV   = 11;

  localparam logic [4:0] SPEED_NORMAL = 5'd18;
  localparam logic [4:0] SPEED_AUTO   = 5'd31;
  localparam logic [3:0] CODE_COOL    = 4'h4;
  localparam logic [3:0] CODE_DRY     = 4'hA;
  localparam logic [3:0] CODE_CLEAN   = 4'h8;
  localparam logic [6:0] LEVEL_AUTO   = 7'd0;
  localparam logic [6:0] LEVEL_DRY    = 7'd60;
  localparam logic [6:0] LEVEL_CLEAN  = 7'd24;

  // pulse timing in microseconds
  localparam logic [MARK_W-1:0]  HDR_MARK   = 14'd8400;
  localparam logic [SPACE_W-1:0] HDR_SPACE  = 13'd4150;
  localparam logic [MARK_W-1:0]  BIT_MARK   = 14'd550;
  localparam logic [SPACE_W-1:0] ONE_SPACE  = 13'd1540;
  localparam logic [SPACE_W-1:0] ZERO_SPACE = 13'd500;
  localparam logic [MARK_W-1:0]  FTR_MARK   = 14'd500;
  localparam logic [SPACE_W-1:0] FTR_SPACE  = 13'd500;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic [2:0]            cur_mode;
    logic [2:0]            prev_mode;
    logic [1:0]            count;
    logic signed [10:0]    target;
  } acfe_state_t;

  typedef struct packed {
    logic [6:0] temp_min;
    logic [6:0] temp_max;
    logic [7:0] threshold;
  } acfe_cfg_t;

  typedef struct packed {
    logic               action;
    logic [2:0]         mode;
    logic signed [10:0] target;
    logic signed [10:0] current;
  } acfe_item_t;

endpackage

// ----- hw/rtl/acfe_frame_update.sv -----
// acfe_frame_update: combinational update of mode state and the 48-bit frame
// for one registered input item. Depends on acfe_pkg.
module acfe_frame_update (
  input  acfe_pkg::acfe_item_t  item_i,
  input  acfe_pkg::acfe_state_t state_i,
  input  acfe_pkg::acfe_cfg_t   cfg_i,
  output logic                  send_o,
  output acfe_pkg::acfe_state_t state_o
);

  logic [2:0]          req_mode;
  logic signed [10:0]  tgt;
  logic [11:0]         thr10;
  logic signed [12:0]  limit;
  logic signed [12:0]  cur_ext;
  logic                switch_auto;
  logic [2:0]          m;
  logic [2:0]          ctl;
  logic [10:0]         lo10;
  logic [10:0]         hi10;
  logic signed [11:0]  t_s;
  logic signed [11:0]  t_lo;
  logic signed [11:0]  t_cl;
  logic [10:0]         t_plus;
  logic [23:0]         prod;
  logic [6:0]          level;
  logic [1:0]          count;
  logic [7:0]          sum;
  logic [acfe_pkg::FRAME_BITS-1:0] fw;

  always_comb begin
    // report: cool falls back to auto when room is at or below target + margin
    thr10   = {4'b0, cfg_i.threshold} * 12'd10;
    limit   = 13'(state_i.target) + $signed({1'b0, thr10});
    cur_ext = 13'(item_i.current);
    switch_auto = (state_i.cur_mode == acfe_pkg::MODE_COOL) && (cur_ext <= limit);

    if (item_i.action == acfe_pkg::ACT_COMMAND) begin
      send_o   = 1'b1;
      req_mode = item_i.mode;
      tgt      = item_i.target;
    end else begin
      send_o   = switch_auto;
      req_mode = acfe_pkg::MODE_AUTO;
      tgt      = state_i.target;
    end

    m = req_mode;
    if (m == acfe_pkg::MODE_AUTO && state_i.prev_mode == acfe_pkg::MODE_OFF) begin
      m = acfe_pkg::MODE_COOL;
    end
    ctl = (m == acfe_pkg::MODE_OFF) ? state_i.prev_mode : m;

    // clamp low then high, round half up; result is always in 0..1270
    lo10 = {4'b0, cfg_i.temp_min} * 11'd10;
    hi10 = {4'b0, cfg_i.temp_max} * 11'd10;
    t_s  = 12'(tgt);
    t_lo = (t_s < $signed({1'b0, lo10})) ? $signed({1'b0, lo10}) : t_s;
    t_cl = (t_lo > $signed({1'b0, hi10})) ? $signed({1'b0, hi10}) : t_lo;
    t_plus = t_cl[10:0] + 11'd5;
    prod   = {13'b0, t_plus} * 24'd6554;  // /10 by reciprocal, exact below 1300
    level  = prod[22:16];

    fw = state_i.frame;
    if (m inside {[acfe_pkg::MODE_COOL:acfe_pkg::MODE_CLEAN]}) begin
      fw[acfe_pkg::POS_POWER] = 1'b1;
    end else if (m == acfe_pkg::MODE_OFF) begin
      fw[acfe_pkg::POS_POWER] = 1'b0;
    end

    case (ctl)
      acfe_pkg::MODE_COOL: begin
        fw[acfe_pkg::POS_SPEED +: 5] = acfe_pkg::SPEED_NORMAL;
        fw[acfe_pkg::POS_PMV]        = 1'b0;
        fw[acfe_pkg::POS_MODE +: 4]  = acfe_pkg::CODE_COOL;
      end
      acfe_pkg::MODE_AUTO: begin
        fw[acfe_pkg::POS_SPEED +: 5] = acfe_pkg::SPEED_AUTO;
        fw[acfe_pkg::POS_PMV]        = 1'b1;
        fw[acfe_pkg::POS_MODE +: 4]  = acfe_pkg::CODE_COOL;
        level = acfe_pkg::LEVEL_AUTO;
      end
      acfe_pkg::MODE_DRY: begin
        fw[acfe_pkg::POS_SPEED +: 5] = acfe_pkg::SPEED_AUTO;
        fw[acfe_pkg::POS_PMV]        = 1'b0;
        fw[acfe_pkg::POS_MODE +: 4]  = acfe_pkg::CODE_DRY;
        level = acfe_pkg::LEVEL_DRY;
      end
      acfe_pkg::MODE_CLEAN: begin
        fw[acfe_pkg::POS_SPEED +: 5] = acfe_pkg::SPEED_NORMAL;
        fw[acfe_pkg::POS_PMV]        = 1'b0;
        fw[acfe_pkg::POS_MODE +: 4]  = acfe_pkg::CODE_CLEAN;
        level = acfe_pkg::LEVEL_CLEAN;
      end
      default: begin
        // off after off, or undefined codes: fan fields untouched
      end
    endcase
    fw[acfe_pkg::POS_LEVEL +: 7] = level;

    count = state_i.count + 2'd1;
    fw[acfe_pkg::POS_COUNT +: 2] = count;

    sum = fw[15:8] + fw[23:16] + fw[31:24] + fw[39:32] + fw[47:40];
    fw[7:0] = sum;

    state_o = state_i;
    if (send_o) begin
      state_o.frame     = fw;
      state_o.cur_mode  = m;
      state_o.prev_mode = m;
      state_o.count     = count;
      state_o.target    = tgt;
    end
  end

endmodule

// ----- hw/rtl/acfe_serializer.sv -----
// acfe_serializer: turns a finished frame into header, 48 data and footer pulses.
// Depends on acfe_pkg.
module acfe_serializer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_valid_i,
  input  logic [acfe_pkg::FRAME_BITS-1:0]     load_frame_i,
  output logic                                load_ready_o,
  output logic                                pulse_valid_o,
  input  logic                                pulse_ready_i,
  output logic [acfe_pkg::MARK_W-1:0]         mark_o,
  output logic [acfe_pkg::SPACE_W-1:0]        space_o,
  output logic [acfe_pkg::FRAME_BITS-1:0]     frame_o,
  output logic                                last_o
);

  localparam logic [acfe_pkg::IDX_W-1:0] IDX_LAST = acfe_pkg::IDX_W'(acfe_pkg::PULSES - 1);
  localparam logic [acfe_pkg::IDX_W-1:0] IDX_ONE  = acfe_pkg::IDX_W'(1);

  logic                            valid_q, valid_d;
  logic [acfe_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic [acfe_pkg::FRAME_BITS-1:0] frame_q, frame_d;
  logic [acfe_pkg::FRAME_BITS-1:0] sh_q, sh_d;
  logic                            xfer;
  logic                            is_hdr;

  assign xfer         = valid_q && pulse_ready_i;
  assign last_o       = (idx_q == IDX_LAST);
  assign is_hdr       = (idx_q == '0);
  assign load_ready_o = !valid_q || (xfer && last_o);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    frame_d = frame_q;
    sh_d    = sh_q;
    if (xfer) begin
      idx_d = idx_q + IDX_ONE;
      if (!is_hdr) begin
        sh_d = {sh_q[acfe_pkg::FRAME_BITS-2:0], 1'b0};
      end
      if (last_o) begin
        valid_d = 1'b0;
      end
    end
    if (load_ready_o && load_valid_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
      frame_d = load_frame_i;
      sh_d    = load_frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    sh_q    <= sh_d;
  end

  always_comb begin
    if (is_hdr) begin
      mark_o  = acfe_pkg::HDR_MARK;
      space_o = acfe_pkg::HDR_SPACE;
    end else if (last_o) begin
      mark_o  = acfe_pkg::FTR_MARK;
      space_o = acfe_pkg::FTR_SPACE;
    end else begin
      mark_o  = acfe_pkg::BIT_MARK;
      space_o = sh_q[acfe_pkg::FRAME_BITS-1] ? acfe_pkg::ONE_SPACE : acfe_pkg::ZERO_SPACE;
    end
  end

  assign pulse_valid_o = valid_q;
  assign frame_o       = frame_q;

endmodule

// ----- hw/rtl/ac_ir_frame_encoder.sv -----
// ac_ir_frame_encoder: top level of the IR remote frame encoder.
// Depends on acfe_pkg, acfe_frame_update and acfe_serializer.
//
// channel  | dir | handshake              | payload
// s_axis   | in  | tvalid / tready        | tuser: action; tdata: mode, target, current
// m_axis   | out | tvalid / tready, tlast | tdata: mark_us, space_us, frame
// cfg      | in  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A sending item yields 50 pulses, one per cycle while m_axis_tready_i is high,
// so the pulse serializer sets the frame rate. An input register and a
// one-frame buffer sit ahead of it, so the next item is taken while a frame is
// still going out; a report that causes no switch never waits on the buffer.
// Reset restores the default frame, mode off and the register reset values.
module ac_ir_frame_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [2:0] mode, [13:3] target_tenths, [24:14] current_tenths
  input  logic        s_axis_tuser_i,   // [0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // [13:0] mark_us, [26:14] space_us, [74:27] frame
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  logic                  in_valid_q, in_valid_d;
  acfe_pkg::acfe_item_t  item_q, item_d;
  acfe_pkg::acfe_state_t state_q, state_d, state_upd;
  acfe_pkg::acfe_cfg_t   cfg_q, cfg_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [acfe_pkg::FRAME_BITS-1:0] pend_frame_q, pend_frame_d;
  logic                  send;
  logic                  advance;
  logic                  pend_take;
  logic                  load_ready;
  logic [acfe_pkg::MARK_W-1:0]     mark;
  logic [acfe_pkg::SPACE_W-1:0]    space;
  logic [acfe_pkg::FRAME_BITS-1:0] frame;

  acfe_frame_update u_update (
    .item_i  (item_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .send_o  (send),
    .state_o (state_upd)
  );

  assign pend_take = pend_valid_q && load_ready;
  assign advance   = in_valid_q && (!send || !pend_valid_q || pend_take);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d   = in_valid_q;
    item_d       = item_q;
    state_d      = state_q;
    pend_valid_d = pend_valid_q;
    pend_frame_d = pend_frame_q;
    cfg_d        = cfg_q;

    if (pend_take) begin
      pend_valid_d = 1'b0;
    end
    if (advance) begin
      in_valid_d = 1'b0;
      state_d    = state_upd;
      if (send) begin
        pend_valid_d = 1'b1;
        pend_frame_d = state_upd.frame;
      end
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_d     = 1'b1;
      item_d.action  = s_axis_tuser_i;
      item_d.mode    = s_axis_tdata_i[2:0];
      item_d.target  = s_axis_tdata_i[13:3];
      item_d.current = s_axis_tdata_i[24:14];
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        acfe_pkg::REG_TEMP_MIN:  cfg_d.temp_min  = cfg_data_i[6:0];
        acfe_pkg::REG_TEMP_MAX:  cfg_d.temp_max  = cfg_data_i[6:0];
        acfe_pkg::REG_THRESHOLD: cfg_d.threshold = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q        <= 1'b0;
      pend_valid_q      <= 1'b0;
      state_q.frame     <= acfe_pkg::FRAME_RESET;
      state_q.cur_mode  <= acfe_pkg::MODE_OFF;
      state_q.prev_mode <= acfe_pkg::MODE_OFF;
      state_q.count     <= 2'd0;
      state_q.target    <= 11'sd0;
      cfg_q.temp_min    <= 7'd17;
      cfg_q.temp_max    <= 7'd30;
      cfg_q.threshold   <= 8'd0;
    end else begin
      in_valid_q   <= in_valid_d;
      pend_valid_q <= pend_valid_d;
      state_q      <= state_d;
      cfg_q        <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    pend_frame_q <= pend_frame_d;
  end

  acfe_serializer u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_valid_i  (pend_valid_q),
    .load_frame_i  (pend_frame_q),
    .load_ready_o  (load_ready),
    .pulse_valid_o (m_axis_tvalid_o),
    .pulse_ready_i (m_axis_tready_i),
    .mark_o        (mark),
    .space_o       (space),
    .frame_o       (frame),
    .last_o        (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'b0, frame, space, mark};

endmodule
